FILE: rtl/owbm_pkg.sv
// package for the 1-wire bus master: types, codes and timing register helpers
`default_nettype none

package owbm_pkg;

	localparam int COUNT_WIDTH_DEF = 12;
	localparam int REG_WIDTH       = 12;
	localparam int APB_ADDR_WIDTH  = 5;
	localparam int APB_DATA_WIDTH  = 32;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [2:0] REG_RESET_LOW      = 3'd0;
	localparam logic [2:0] REG_PRESENCE_WAIT  = 3'd1;
	localparam logic [2:0] REG_RESET_RECOVERY = 3'd2;
	localparam logic [2:0] REG_SLOT_LOW       = 3'd3;
	localparam logic [2:0] REG_READ_SAMPLE    = 3'd4;
	localparam logic [2:0] REG_SLOT_HOLD      = 3'd5;
	localparam logic [2:0] REG_SLOT_RECOVERY  = 3'd6;

	localparam logic [11:0] DEF_RESET_LOW      = 12'd480;
	localparam logic [11:0] DEF_PRESENCE_WAIT  = 12'd70;
	localparam logic [11:0] DEF_RESET_RECOVERY = 12'd410;
	localparam logic [7:0]  DEF_SLOT_LOW       = 8'd5;
	localparam logic [7:0]  DEF_READ_SAMPLE    = 8'd5;
	localparam logic [11:0] DEF_SLOT_HOLD      = 12'd60;
	localparam logic [7:0]  DEF_SLOT_RECOVERY  = 8'd2;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_RST_REC  = 4'd3,
		PH_W_LOW    = 4'd4,
		PH_W_HOLD   = 4'd5,
		PH_W_REC    = 4'd6,
		PH_R_LOW    = 4'd7,
		PH_R_WAIT   = 4'd8,
		PH_R_HOLD   = 4'd9,
		PH_R_REC    = 4'd10
	} phase_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] write_byte;
		logic       line_level;
	} in_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence_seen;
		logic [7:0] read_byte;
	} out_t;

	typedef struct packed {
		logic [11:0] reset_low;
		logic [11:0] presence_wait;
		logic [11:0] reset_recovery;
		logic [7:0]  slot_low;
		logic [7:0]  read_sample;
		logic [11:0] slot_hold;
		logic [7:0]  slot_recovery;
	} cfg_t;

	// raw timing value that governs a phase
	function automatic logic [REG_WIDTH-1:0] phase_limit(input cfg_t cfg, input phase_t ph);
		logic [REG_WIDTH-1:0] v;
		begin
			unique case (ph) inside
				PH_RST_LOW:           v = cfg.reset_low;
				PH_RST_WAIT:          v = cfg.presence_wait;
				PH_RST_REC:           v = cfg.reset_recovery;
				PH_W_LOW, PH_R_LOW:   v = REG_WIDTH'(cfg.slot_low);
				PH_R_WAIT:            v = REG_WIDTH'(cfg.read_sample);
				PH_W_HOLD, PH_R_HOLD: v = cfg.slot_hold;
				default:              v = REG_WIDTH'(cfg.slot_recovery);
			endcase
			return v;
		end
	endfunction

endpackage

`default_nettype wire

FILE: rtl/owbm_regs.sv
// apb timing register file for the 1-wire bus master
`default_nettype none

module owbm_regs (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire [owbm_pkg::APB_ADDR_WIDTH-1:0]  paddr,
	input  wire [owbm_pkg::APB_DATA_WIDTH-1:0]  pwdata,
	output logic [owbm_pkg::APB_DATA_WIDTH-1:0] prdata,
	output logic                                pready,
	output owbm_pkg::cfg_t                      cfg
);
	import owbm_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low      <= DEF_RESET_LOW;
			cfg_q.presence_wait  <= DEF_PRESENCE_WAIT;
			cfg_q.reset_recovery <= DEF_RESET_RECOVERY;
			cfg_q.slot_low       <= DEF_SLOT_LOW;
			cfg_q.read_sample    <= DEF_READ_SAMPLE;
			cfg_q.slot_hold      <= DEF_SLOT_HOLD;
			cfg_q.slot_recovery  <= DEF_SLOT_RECOVERY;
		end else if (wr_en) begin
			unique case (idx)
				REG_RESET_LOW:      cfg_q.reset_low      <= pwdata[11:0];
				REG_PRESENCE_WAIT:  cfg_q.presence_wait  <= pwdata[11:0];
				REG_RESET_RECOVERY: cfg_q.reset_recovery <= pwdata[11:0];
				REG_SLOT_LOW:       cfg_q.slot_low       <= pwdata[7:0];
				REG_READ_SAMPLE:    cfg_q.read_sample    <= pwdata[7:0];
				REG_SLOT_HOLD:      cfg_q.slot_hold      <= pwdata[11:0];
				REG_SLOT_RECOVERY:  cfg_q.slot_recovery  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RESET_LOW:      prdata = APB_DATA_WIDTH'(cfg_q.reset_low);
			REG_PRESENCE_WAIT:  prdata = APB_DATA_WIDTH'(cfg_q.presence_wait);
			REG_RESET_RECOVERY: prdata = APB_DATA_WIDTH'(cfg_q.reset_recovery);
			REG_SLOT_LOW:       prdata = APB_DATA_WIDTH'(cfg_q.slot_low);
			REG_READ_SAMPLE:    prdata = APB_DATA_WIDTH'(cfg_q.read_sample);
			REG_SLOT_HOLD:      prdata = APB_DATA_WIDTH'(cfg_q.slot_hold);
			REG_SLOT_RECOVERY:  prdata = APB_DATA_WIDTH'(cfg_q.slot_recovery);
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/owbm_seq.sv
// 1-wire phase sequencer: one tick request per step
`default_nettype none

module owbm_seq #(
	parameter int COUNT_WIDTH = owbm_pkg::COUNT_WIDTH_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            step,
	input  owbm_pkg::in_t  item,
	input  owbm_pkg::cfg_t cfg,
	output owbm_pkg::out_t res
);
	import owbm_pkg::*;

	localparam int LIM_W = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	phase_t                 phase_q, phase_d, ph;
	logic [COUNT_WIDTH-1:0] tick_q, tick_d, tick_b, tick_inc, lim;
	logic [2:0]             bit_q, bit_d, bit_b;
	logic [7:0]             shift_q, shift_d, shift_b;
	logic                   presence_q, presence_d;
	logic [7:0]             last_q, last_d;
	logic                   done_c;
	logic                   drive_c;
	logic [REG_WIDTH-1:0]   raw;
	logic [LIM_W-1:0]       lim_ext;

	// effective timing limit: zero acts as one, saturate at counter range
	always_comb begin
		raw     = phase_limit(cfg, ph);
		lim_ext = LIM_W'(raw);
		if (raw == '0)
			lim_ext = LIM_W'(1);
		if (lim_ext > LIM_W'(CNT_MAX))
			lim_ext = LIM_W'(CNT_MAX);
		lim = lim_ext[COUNT_WIDTH-1:0];
	end

	always_comb begin : next_state
		ph         = phase_q;
		tick_b     = tick_q;
		bit_b      = bit_q;
		shift_b    = shift_q;
		if (phase_q == PH_IDLE) begin
			tick_b = '0;
			bit_b  = '0;
			unique case (item.op)
				OP_RESET: ph = PH_RST_LOW;
				OP_WRITE: begin
					shift_b = item.write_byte;
					ph      = PH_W_LOW;
				end
				OP_READ: begin
					shift_b = '0;
					ph      = PH_R_LOW;
				end
				default: ;
			endcase
		end
		tick_inc   = tick_b + 1'b1;
		phase_d    = ph;
		tick_d     = tick_b;
		bit_d      = bit_b;
		shift_d    = shift_b;
		presence_d = presence_q;
		last_d     = last_q;
		done_c     = 1'b0;
		if (ph != PH_IDLE) begin
			tick_d = tick_inc;
			if (tick_inc >= lim) begin
				tick_d = '0;
				unique case (ph)
					PH_IDLE:     ;
					PH_RST_LOW:  phase_d = PH_RST_WAIT;
					PH_RST_WAIT: begin
						presence_d = ~item.line_level;
						phase_d    = PH_RST_REC;
					end
					PH_RST_REC: begin
						if (presence_q) begin
							phase_d = PH_IDLE;
							done_c  = 1'b1;
						end else begin
							phase_d = PH_RST_LOW;
						end
					end
					PH_W_LOW:    phase_d = PH_W_HOLD;
					PH_W_HOLD: begin
						shift_d = {1'b0, shift_b[7:1]};
						if (bit_b == 3'd7) begin
							phase_d = PH_IDLE;
							done_c  = 1'b1;
							bit_d   = '0;
						end else begin
							bit_d   = bit_b + 3'd1;
							phase_d = PH_W_REC;
						end
					end
					PH_W_REC:    phase_d = PH_W_LOW;
					PH_R_LOW:    phase_d = PH_R_WAIT;
					PH_R_WAIT: begin
						shift_d = {item.line_level, shift_b[7:1]};
						phase_d = PH_R_HOLD;
					end
					PH_R_HOLD: begin
						if (bit_b == 3'd7) begin
							last_d  = shift_b;
							phase_d = PH_IDLE;
							done_c  = 1'b1;
							bit_d   = '0;
						end else begin
							bit_d   = bit_b + 3'd1;
							phase_d = PH_R_REC;
						end
					end
					PH_R_REC:    phase_d = PH_R_LOW;
					default:     phase_d = PH_IDLE;
				endcase
			end
		end
	end

	always_comb begin : outputs
		unique case (ph) inside
			PH_RST_LOW, PH_W_LOW, PH_R_LOW: drive_c = 1'b1;
			PH_W_HOLD:                      drive_c = ~shift_b[0];
			default:                        drive_c = 1'b0;
		endcase
		res.drive_low     = drive_c;
		res.busy_res      = (phase_d != PH_IDLE);
		res.done_res      = done_c;
		res.presence_seen = presence_d;
		res.read_byte     = last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			tick_q     <= '0;
			bit_q      <= '0;
			shift_q    <= '0;
			presence_q <= 1'b0;
			last_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			tick_q     <= tick_d;
			bit_q      <= bit_d;
			shift_q    <= shift_d;
			presence_q <= presence_d;
			last_q     <= last_d;
		end
	end

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |-> !res.busy_res)
		else $error("done raised while still busy");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |=> phase_q == PH_IDLE)
		else $error("sequencer not idle after completion");

	a_idle_bit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> bit_q == 3'd0)
		else $error("bit index left set while idle");

	a_idle_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_IDLE && item.op == OP_TICK |-> !res.drive_low && !res.busy_res)
		else $error("idle tick drove the line");

endmodule

`default_nettype wire

FILE: rtl/one_wire_bus_master_top.sv
// top level of the tick-driven 1-wire bus master
// each input request is one timing tick carrying an op (tick only, reset, write
// byte, read byte), the byte to write and the sampled bus level; each request
// yields exactly one result: drive_low for the open-drain pad, busy, done,
// the presence flag and the last byte read. commands start only when idle.
// the request is captured in an input register, the phase sequencer works on
// it from there and its result lands in the output register, so a result
// passes through both registers, and one request is taken every cycle while
// the receiver does not stall. the limit is the single sequencer pass per tick.
// when the receiver stalls, the output register holds its result and the
// input register holds one further request; after that the input side is
// stalled too, and nothing is lost or repeated.
// timing registers sit on an apb port at byte address 4*index, pready always
// high; write them only while no command is in progress.
// reset (arst_n low) returns the sequencer to idle, clears presence and the
// read byte, and loads the default timings.
`default_nettype none

module one_wire_bus_master_top #(
	parameter int COUNT_WIDTH = owbm_pkg::COUNT_WIDTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  owbm_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output owbm_pkg::out_t                      out_data,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire [owbm_pkg::APB_ADDR_WIDTH-1:0]  paddr,
	input  wire [owbm_pkg::APB_DATA_WIDTH-1:0]  pwdata,
	output logic [owbm_pkg::APB_DATA_WIDTH-1:0] prdata,
	output logic                                pready
);
	import owbm_pkg::*;

	cfg_t cfg;
	in_t  item_s1;
	logic valid_s1;
	out_t res;
	out_t out_q;
	logic out_valid_q;
	logic advance;
	logic accept;

	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	owbm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	owbm_seq #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire
